>>> rtl/tta_pkg.sv
package tta_pkg;

    localparam int NUM_DIMS = 4;
    localparam int RANK_W   = 3;
    localparam int SIZE_W   = 13;
    localparam int CFG_W    = 13;
    localparam int PERM_W   = 8;
    localparam int DATA_W   = 32;
    localparam int OUT_ADDR_W = 48;

    typedef enum logic [2:0] {
        REG_RANK    = 3'd0,
        REG_DIM0    = 3'd1,
        REG_DIM1    = 3'd2,
        REG_DIM2    = 3'd3,
        REG_DIM3    = 3'd4,
        REG_PERM    = 3'd5,
        REG_REVERSE = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [RANK_W-1:0]              rank;
        logic [NUM_DIMS-1:0][SIZE_W-1:0] dim;
        logic [PERM_W-1:0]              perm;
        logic                           reverse;
    } cfg_t;

    // rank in use: zero acts as one, anything above the cap saturates
    function automatic logic [RANK_W-1:0] live_rank(logic [RANK_W-1:0] raw, int cap);
        logic [RANK_W-1:0] r;
        r = raw;
        if (r == '0)
            r = RANK_W'(1);
        if (r > RANK_W'(cap))
            r = RANK_W'(cap);
        return r;
    endfunction

    // size of dimension d; size one above rank, zero acts as one, saturates at 2^dim_bits
    function automatic logic [SIZE_W-1:0] live_size(cfg_t c, logic [1:0] d,
                                                    logic [RANK_W-1:0] r, int dim_bits);
        logic [SIZE_W-1:0] v;
        logic [SIZE_W:0]   lim;
        v = c.dim[d];
        lim = (dim_bits >= SIZE_W) ? {1'b1, {SIZE_W{1'b0}}} : ((SIZE_W+1)'(1) << dim_bits);
        if ({1'b0, d} >= r)
            v = SIZE_W'(1);
        else if (v == '0)
            v = SIZE_W'(1);
        else if ({1'b0, v} > lim)
            v = lim[SIZE_W-1:0];
        return v;
    endfunction

    // input dimension placed at output position i
    function automatic logic [RANK_W-1:0] perm_entry(cfg_t c, logic [1:0] i,
                                                     logic [RANK_W-1:0] r);
        logic [RANK_W-1:0] e;
        if (c.reverse)
            e = r - RANK_W'(1) - {1'b0, i};
        else
            e = {1'b0, c.perm[2*i +: 2]};
        return e;
    endfunction

endpackage

>>> rtl/tensor_transpose_address_gen.sv
// An accepted beat passes through the product stage (a_*) and then the output register (b_*).
// Throughput: one beat per cycle while s_tready is high; the output register and
// product stage absorb stalls. After reset and after every configuration write the
// stride unit runs (one multiply per output position); s_tready is low meanwhile.
// Reset (rst_n, async, active low) restores the default configuration and clears
// the odometer and pipeline valids.
module tensor_transpose_address_gen #(
    parameter int MAX_RANK  = 4,
    parameter int DIM_BITS  = 12,
    parameter int ADDR_BITS = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [2:0]                  cfg_index,
    input  logic [tta_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [31:0] element_value
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [79:0]                 m_tdata,   // [47:0] output_address, [79:48] element_data
    output logic                        m_tlast,   // last_element
    output logic                        m_tuser    // bad_permutation
);

    localparam int EW = (ADDR_BITS > tta_pkg::OUT_ADDR_W) ? ADDR_BITS : tta_pkg::OUT_ADDR_W;

    tta_pkg::cfg_t cfg_reg;

    logic [ADDR_BITS-1:0] shadow_stride [tta_pkg::NUM_DIMS];
    logic                 shadow_fault;
    logic                 seq_busy;

    logic [DIM_BITS-1:0]  index [tta_pkg::NUM_DIMS];
    logic                 odo_idle;
    logic                 odo_last;

    logic [ADDR_BITS-1:0] stride_live_reg [tta_pkg::NUM_DIMS];
    logic                 fault_live_reg;
    logic [ADDR_BITS-1:0] stride_sel [tta_pkg::NUM_DIMS];
    logic                 fault_sel;

    logic                              a_valid_reg;
    logic [ADDR_BITS-1:0]              a_prod_reg [tta_pkg::NUM_DIMS];
    logic [tta_pkg::DATA_W-1:0]        a_data_reg;
    logic                              a_last_reg;
    logic                              a_fault_reg;

    logic                              b_valid_reg;
    logic [tta_pkg::OUT_ADDR_W-1:0]    b_addr_reg;
    logic [tta_pkg::DATA_W-1:0]        b_data_reg;
    logic                              b_last_reg;
    logic                              b_fault_reg;

    logic                 b_en;
    logic                 a_en;
    logic                 accept;
    logic [ADDR_BITS-1:0] sum;
    logic [EW-1:0]        sum_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rank    <= tta_pkg::RANK_W'(4);
            cfg_reg.dim[0]  <= tta_pkg::SIZE_W'(1);
            cfg_reg.dim[1]  <= tta_pkg::SIZE_W'(1);
            cfg_reg.dim[2]  <= tta_pkg::SIZE_W'(1);
            cfg_reg.dim[3]  <= tta_pkg::SIZE_W'(1);
            cfg_reg.perm    <= 8'h1b;
            cfg_reg.reverse <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (tta_pkg::reg_index_t'(cfg_index))
                tta_pkg::REG_RANK:    cfg_reg.rank    <= cfg_data[tta_pkg::RANK_W-1:0];
                tta_pkg::REG_DIM0:    cfg_reg.dim[0]  <= cfg_data[tta_pkg::SIZE_W-1:0];
                tta_pkg::REG_DIM1:    cfg_reg.dim[1]  <= cfg_data[tta_pkg::SIZE_W-1:0];
                tta_pkg::REG_DIM2:    cfg_reg.dim[2]  <= cfg_data[tta_pkg::SIZE_W-1:0];
                tta_pkg::REG_DIM3:    cfg_reg.dim[3]  <= cfg_data[tta_pkg::SIZE_W-1:0];
                tta_pkg::REG_PERM:    cfg_reg.perm    <= cfg_data[tta_pkg::PERM_W-1:0];
                tta_pkg::REG_REVERSE: cfg_reg.reverse <= cfg_data[0];
                default: ;
            endcase
        end
    end

    tta_stride_seq #(
        .MAX_RANK  (MAX_RANK),
        .DIM_BITS  (DIM_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_stride_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .restart (cfg_write),
        .stride  (shadow_stride),
        .fault   (shadow_fault),
        .busy    (seq_busy)
    );

    tta_odometer #(
        .MAX_RANK (MAX_RANK),
        .DIM_BITS (DIM_BITS)
    ) u_odometer (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .advance (accept),
        .index   (index),
        .idle    (odo_idle),
        .last    (odo_last)
    );

    assign b_en     = !b_valid_reg || m_tready;
    assign a_en     = !a_valid_reg || b_en;
    assign s_tready = a_en && !seq_busy && !cfg_write;
    assign accept   = s_tvalid && s_tready;

    // a beat at odometer zero picks up the freshly computed strides
    always_comb
    begin
        for (int d = 0; d < tta_pkg::NUM_DIMS; d++)
            stride_sel[d] = odo_idle ? shadow_stride[d] : stride_live_reg[d];
        fault_sel = odo_idle ? shadow_fault : fault_live_reg;
    end

    always_comb
    begin
        sum = '0;
        for (int d = 0; d < tta_pkg::NUM_DIMS; d++)
            sum = sum + a_prod_reg[d];
        sum_ext = EW'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
                a_valid_reg <= accept;
            if (b_en)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (odo_idle)
            begin
                for (int d = 0; d < tta_pkg::NUM_DIMS; d++)
                    stride_live_reg[d] <= shadow_stride[d];
                fault_live_reg <= shadow_fault;
            end
            for (int d = 0; d < tta_pkg::NUM_DIMS; d++)
                a_prod_reg[d] <= ADDR_BITS'(index[d] * stride_sel[d]);
            a_data_reg  <= s_tdata;
            a_last_reg  <= odo_last;
            a_fault_reg <= fault_sel;
        end
        if (b_en && a_valid_reg)
        begin
            b_addr_reg  <= a_fault_reg ? '0 : sum_ext[tta_pkg::OUT_ADDR_W-1:0];
            b_data_reg  <= a_data_reg;
            b_last_reg  <= a_last_reg;
            b_fault_reg <= a_fault_reg;
        end
    end

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = {b_data_reg, b_addr_reg};
    assign m_tlast  = b_last_reg;
    assign m_tuser  = b_fault_reg;

endmodule

>>> rtl/tta_stride_seq.sv
module tta_stride_seq #(
    parameter int MAX_RANK  = 4,
    parameter int DIM_BITS  = 12,
    parameter int ADDR_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tta_pkg::cfg_t        cfg,
    input  logic                 restart,
    output logic [ADDR_BITS-1:0] stride [tta_pkg::NUM_DIMS],
    output logic                 fault,
    output logic                 busy
);

    localparam int RANK_CAP = (MAX_RANK < 4) ? MAX_RANK : 4;

    logic                 busy_reg;
    logic                 init_reg;
    logic                 fault_reg;
    logic [1:0]           step_reg;
    logic [ADDR_BITS-1:0] acc_reg;
    logic [ADDR_BITS-1:0] stride_reg [tta_pkg::NUM_DIMS];

    logic [tta_pkg::RANK_W-1:0] rank;
    logic                       fault_calc;
    logic [tta_pkg::RANK_W-1:0] cur_entry;
    logic [1:0]                 cur_dim;
    logic [tta_pkg::SIZE_W-1:0] cur_size;
    logic [ADDR_BITS-1:0]       acc_next;

    always_comb
    begin
        rank = tta_pkg::live_rank(cfg.rank, RANK_CAP);
        fault_calc = 1'b0;
        for (int i = 0; i < tta_pkg::NUM_DIMS; i++)
        begin
            if ((tta_pkg::RANK_W'(i) < rank) &&
                (tta_pkg::perm_entry(cfg, 2'(i), rank) >= rank))
                fault_calc = 1'b1;
        end
        cur_entry = tta_pkg::perm_entry(cfg, step_reg, rank);
        cur_dim   = cur_entry[1:0];
        cur_size  = tta_pkg::live_size(cfg, cur_dim, rank, DIM_BITS);
        acc_next  = ADDR_BITS'(acc_reg * cur_size);
    end

    // walk output positions from innermost outward, one multiply per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            init_reg  <= 1'b1;
            fault_reg <= 1'b0;
            step_reg  <= '0;
        end
        else if (restart)
        begin
            busy_reg <= 1'b1;
            init_reg <= 1'b1;
        end
        else if (init_reg)
        begin
            init_reg  <= 1'b0;
            fault_reg <= fault_calc;
            step_reg  <= 2'(rank - tta_pkg::RANK_W'(1));
            if (fault_calc)
                busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!restart && init_reg)
        begin
            acc_reg <= ADDR_BITS'(1);
            for (int i = 0; i < tta_pkg::NUM_DIMS; i++)
                stride_reg[i] <= '0;
        end
        else if (!restart && busy_reg)
        begin
            stride_reg[cur_dim] <= stride_reg[cur_dim] + acc_reg;
            acc_reg <= acc_next;
        end
    end

    assign stride = stride_reg;
    assign fault  = fault_reg;
    assign busy   = busy_reg;

endmodule

>>> rtl/tta_odometer.sv
module tta_odometer #(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tta_pkg::cfg_t       cfg,
    input  logic                advance,
    output logic [DIM_BITS-1:0] index [tta_pkg::NUM_DIMS],
    output logic                idle,
    output logic                last
);

    localparam int RANK_CAP = (MAX_RANK < 4) ? MAX_RANK : 4;
    localparam int CW = (DIM_BITS + 1 > tta_pkg::SIZE_W) ? DIM_BITS + 1 : tta_pkg::SIZE_W;

    logic [DIM_BITS-1:0] index_reg  [tta_pkg::NUM_DIMS];
    logic [DIM_BITS-1:0] index_eff  [tta_pkg::NUM_DIMS];
    logic [DIM_BITS-1:0] index_next [tta_pkg::NUM_DIMS];

    logic [tta_pkg::RANK_W-1:0]   rank;
    logic [tta_pkg::NUM_DIMS:0]   carry;
    logic [tta_pkg::SIZE_W-1:0]   size;

    always_comb
    begin
        rank = tta_pkg::live_rank(cfg.rank, RANK_CAP);
        idle = 1'b1;
        for (int d = 0; d < tta_pkg::NUM_DIMS; d++)
        begin
            index_eff[d] = (tta_pkg::RANK_W'(d) < rank) ? index_reg[d] : '0;
            if (index_eff[d] != '0)
                idle = 1'b0;
        end
        // dimensions above rank have size one and just pass the carry on
        carry = '0;
        carry[tta_pkg::NUM_DIMS] = 1'b1;
        size = '0;
        for (int d = tta_pkg::NUM_DIMS - 1; d >= 0; d--)
        begin
            size = tta_pkg::live_size(cfg, 2'(d), rank, DIM_BITS);
            index_next[d] = index_eff[d];
            if (carry[d+1])
            begin
                if (CW'(index_eff[d]) + CW'(1) >= CW'(size))
                begin
                    index_next[d] = '0;
                    carry[d] = 1'b1;
                end
                else
                begin
                    index_next[d] = index_eff[d] + DIM_BITS'(1);
                end
            end
        end
        last = carry[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < tta_pkg::NUM_DIMS; d++)
                index_reg[d] <= '0;
        end
        else if (advance)
        begin
            for (int d = 0; d < tta_pkg::NUM_DIMS; d++)
                index_reg[d] <= index_next[d];
        end
    end

    assign index = index_eff;

endmodule
